>>> sv/mpf_pkg.sv
// Shared types and constants for the MQTT packet framer.
`default_nettype none

package mpf_pkg;

    localparam int LEN_W = 28;

    // Byte role codes reported with each result
    localparam logic [1:0] ROLE_HEADER  = 2'd0;
    localparam logic [1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       segment_last;
    } item_t;

    typedef struct packed {
        logic [1:0]       byte_role;
        logic             packet_end;
        logic             malformed;
        logic [LEN_W-1:0] packet_length;
        logic             need_more;
    } result_t;

endpackage

`default_nettype wire

>>> sv/mpf_in_reg.sv
// Input register stage of the MQTT packet framer.
`default_nettype none

module mpf_in_reg
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] byte_value
    input  wire logic          s_tlast,
    output mpf_pkg::item_t     item,
    output logic               item_valid,
    input  wire logic          take
);

    logic           valid_reg;
    logic           valid_next;
    mpf_pkg::item_t item_reg;

    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.byte_value   <= s_tdata;
            item_reg.segment_last <= s_tlast;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

>>> sv/mpf_step.sv
// Framing state and per-byte decode logic of the MQTT packet framer.
`default_nettype none

module mpf_step
#(
    parameter int MAX_LENGTH_BYTES = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mpf_pkg::item_t item,
    input  wire logic          fire,
    output mpf_pkg::result_t   result
);

    localparam int LEN_W = mpf_pkg::LEN_W;

    mpf_pkg::phase_t  phase_reg, phase_next;
    logic [LEN_W-1:0] accum_reg, accum_next;
    logic [2:0]       count_reg, count_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0] group;
    logic [4:0]       shamt;

    // Seven payload bits of a length byte, placed at their group position
    assign shamt = 5'(7 * int'(count_reg[1:0]));
    assign group = {{(LEN_W - 7){1'b0}}, item.byte_value[6:0]} << shamt;

    always_comb
    begin
        phase_next           = phase_reg;
        accum_next           = accum_reg;
        count_next           = count_reg;
        left_next            = left_reg;
        result.byte_role     = mpf_pkg::ROLE_HEADER;
        result.packet_end    = 1'b0;
        result.malformed     = 1'b0;
        result.packet_length = '0;

        unique case (phase_reg)
            mpf_pkg::PH_LENGTH:
            begin
                result.byte_role = mpf_pkg::ROLE_LENGTH;
                accum_next       = accum_reg | group;
                count_next       = count_reg + 3'd1;
                if (!item.byte_value[7])
                begin
                    if (accum_next == '0)
                    begin
                        result.packet_end = 1'b1;
                        phase_next        = mpf_pkg::PH_HEADER;
                    end
                    else
                    begin
                        left_next  = accum_next;
                        phase_next = mpf_pkg::PH_PAYLOAD;
                    end
                end
                else if (count_next >= 3'(MAX_LENGTH_BYTES))
                begin
                    // length field too long: flush and resync on the next byte
                    result.packet_end    = 1'b1;
                    result.malformed     = 1'b1;
                    result.packet_length = accum_next;
                    phase_next           = mpf_pkg::PH_HEADER;
                end
            end
            mpf_pkg::PH_PAYLOAD:
            begin
                result.byte_role = mpf_pkg::ROLE_PAYLOAD;
                left_next        = left_reg - LEN_W'(1);
                if (left_next == '0)
                begin
                    result.packet_end    = 1'b1;
                    result.packet_length = accum_reg;
                    phase_next           = mpf_pkg::PH_HEADER;
                end
            end
            default:
            begin
                accum_next = '0;
                count_next = '0;
                phase_next = mpf_pkg::PH_LENGTH;
            end
        endcase

        result.need_more = item.segment_last && !result.packet_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mpf_pkg::PH_HEADER;
            accum_reg <= '0;
            count_reg <= '0;
            left_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    // Length bytes never run past the configured maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mpf_pkg::PH_LENGTH) |-> (count_reg < 3'(MAX_LENGTH_BYTES)))
        else $error("length byte count past maximum");

    // Payload phase always has bytes left to count
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mpf_pkg::PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with nothing left");

    // A header byte always moves the framer into the length phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == mpf_pkg::PH_HEADER) |=> (phase_reg == mpf_pkg::PH_LENGTH))
        else $error("header byte did not start length decode");

endmodule

`default_nettype wire

>>> sv/mpf_out_reg.sv
// Result register stage of the MQTT packet framer.
`default_nettype none

module mpf_out_reg
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mpf_pkg::result_t result,
    input  wire logic          load,
    output logic               room,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // [0] malformed, [28:1] packet_length,
                                          // [29] need_more, [31:30] zero
    output logic               m_tlast,   // packet_end
    output logic [1:0]         m_tuser    // [1:0] byte_role
);

    logic             valid_reg;
    logic             valid_next;
    mpf_pkg::result_t res_reg;

    assign room = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.need_more, res_reg.packet_length, res_reg.malformed};
    assign m_tlast  = res_reg.packet_end;
    assign m_tuser  = res_reg.byte_role;

endmodule

`default_nettype wire

>>> sv/mqtt_packet_framer_unit.sv
// Top level of the MQTT packet framer: input register, decode step, result register.
// m_tvalid rises once a byte has moved from the input register into the result register.
// Throughput: one byte per cycle unless result back-pressure stalls the state update in mpf_step.
// Back-pressure on the result side stalls the step; the input register absorbs one byte.
// Reset (rst_n low, asynchronous) empties both stages and returns the framer to
// the fixed header phase with the length and payload counters cleared.
`default_nettype none

module mqtt_packet_framer_unit
#(
    parameter int MAX_LENGTH_BYTES = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] byte_value
    input  wire logic          s_tlast,   // segment_last
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // [0] malformed, [28:1] packet_length,
                                          // [29] need_more, [31:30] zero
    output logic               m_tlast,   // packet_end
    output logic [1:0]         m_tuser    // [1:0] byte_role
);

    mpf_pkg::item_t   item;
    mpf_pkg::result_t result;
    logic             item_valid;
    logic             room;
    logic             fire;

    assign fire = item_valid && room;

    mpf_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item       (item),
        .item_valid (item_valid),
        .take       (fire)
    );

    mpf_step #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .fire   (fire),
        .result (result)
    );

    mpf_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .load     (fire),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // A malformed length field is always a flush point on a length byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tlast && m_tuser == mpf_pkg::ROLE_LENGTH))
        else $error("malformed without flush on length byte");

    // need_more and a flush point exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[29]) |-> !m_tlast)
        else $error("need_more on a flush point");

    // The fixed header byte never ends a packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == mpf_pkg::ROLE_HEADER) |-> !m_tlast)
        else $error("flush point on a header byte");

    // Length is reported only at a flush point
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[28:1] == '0))
        else $error("length reported outside a flush point");

endmodule

`default_nettype wire

>>> tb/tb_mqtt_packet_framer_unit.sv
// Testbench for the MQTT packet framer: byte streams checked against a framing predictor.
`timescale 1ns / 1ps

module tb_mqtt_packet_framer_unit;

    localparam int MAX_LEN_BYTES = 4;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [7:0] byte_value
    logic             s_tlast;   // segment_last
    logic             m_tvalid;
    logic             m_tready;
    logic [31:0]      m_tdata;   // [0] malformed, [28:1] packet_length, [29] need_more
    logic             m_tlast;   // packet_end
    logic [1:0]       m_tuser;   // [1:0] byte_role

    // framing predictor state
    mpf_pkg::phase_t          fr_phase;
    logic [mpf_pkg::LEN_W-1:0] len_sum;
    logic [mpf_pkg::LEN_W-1:0] body_left;
    logic [2:0]               len_groups;

    mpf_pkg::result_t byte_verdicts_q[$];
    int               mismatches;
    int               bytes_sent;
    bit               tx_idle;
    bit               rx_idle;
    int               rx_hold;

    mqtt_packet_framer_unit #(
        .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Advances the framing state by one byte and returns what the block must report for it.
    function automatic mpf_pkg::result_t frame_next_byte(input logic [7:0] b,
                                                         input logic seg_last);
        mpf_pkg::result_t          r;
        logic [mpf_pkg::LEN_W-1:0] grp;
        r = '0;
        grp = '0;
        grp[6:0] = b[6:0];
        case (fr_phase)
            mpf_pkg::PH_LENGTH:
            begin
                r.byte_role = mpf_pkg::ROLE_LENGTH;
                len_sum = len_sum | (grp << (7 * (len_groups % 4)));
                len_groups = len_groups + 3'd1;
                if (!b[7])
                begin
                    if (len_sum == '0)
                    begin
                        r.packet_end = 1'b1;
                        fr_phase = mpf_pkg::PH_HEADER;
                    end
                    else
                    begin
                        body_left = len_sum;
                        fr_phase = mpf_pkg::PH_PAYLOAD;
                    end
                end
                else if (len_groups >= MAX_LEN_BYTES)
                begin
                    // continuation still set on the last allowed length byte
                    r.packet_end = 1'b1;
                    r.malformed = 1'b1;
                    r.packet_length = len_sum;
                    fr_phase = mpf_pkg::PH_HEADER;
                end
            end
            mpf_pkg::PH_PAYLOAD:
            begin
                r.byte_role = mpf_pkg::ROLE_PAYLOAD;
                body_left = body_left - 1'b1;
                if (body_left == '0)
                begin
                    r.packet_end = 1'b1;
                    r.packet_length = len_sum;
                    fr_phase = mpf_pkg::PH_HEADER;
                end
            end
            default:
            begin
                r.byte_role = mpf_pkg::ROLE_HEADER;
                len_sum = '0;
                len_groups = '0;
                fr_phase = mpf_pkg::PH_LENGTH;
            end
        endcase
        r.need_more = seg_last && !r.packet_end;
        return r;
    endfunction

    function automatic logic seg_mark(input int odds);
        return (odds != 0) && ($urandom_range(0, odds - 1) == 0);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic seg_last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= seg_last;
        do @(posedge clk); while (!s_tready);
        byte_verdicts_q.push_back(frame_next_byte(b, seg_last));
        bytes_sent++;
    endtask

    // Header, remaining length (optionally padded with zero groups), then payload.
    task automatic send_packet(input logic [7:0] hdr, input int unsigned len, input int pad,
                               input int seg_odds);
        int         groups;
        logic [7:0] lb;
        groups = (len < 128) ? 1 : (len < 16384) ? 2 : (len < 2097152) ? 3 : 4;
        groups = (groups + pad > MAX_LEN_BYTES) ? MAX_LEN_BYTES : groups + pad;
        send_byte(hdr, seg_mark(seg_odds));
        for (int i = 0; i < groups; i++)
        begin
            lb = {(i < groups - 1) ? 1'b1 : 1'b0, 7'(len >> (7 * i))};
            send_byte(lb, seg_mark(seg_odds));
        end
        repeat (len) send_byte(8'($urandom_range(0, 255)), seg_mark(seg_odds));
    endtask

    // Finish whatever packet the stream is in so the next one starts on a header.
    task automatic resync();
        while (fr_phase != mpf_pkg::PH_HEADER)
        begin
            if (fr_phase == mpf_pkg::PH_LENGTH)
                send_byte(8'h00, seg_mark(8));
            else
                send_byte(8'($urandom_range(0, 255)), seg_mark(8));
        end
    endtask

    task automatic test_zero_length();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // zero length spread over all four length bytes, no error
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_malformed_length();
        repeat (2)
        begin
            send_byte(8'h10, 1'b0);
            repeat (MAX_LEN_BYTES) send_byte(8'hFF, 1'b0);
        end
        send_byte(8'h00, 1'b0);
        repeat (MAX_LEN_BYTES) send_byte(8'h80, 1'b0);
    endtask

    task automatic test_padded_length();
        send_packet(8'h32, 2, 3, 0);
        send_packet(8'h30, 1, 0, 0);
    endtask

    task automatic test_segment_marks();
        send_byte(8'h20, 1'b1);
        send_byte(8'h02, 1'b1);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b1);
    endtask

    // Receiver holds off for a long stretch while the sender streams back to back.
    task automatic test_backpressure();
        resync();
        tx_idle = 1'b0;
        rx_hold = 60;
        send_packet(8'h30, 40, 0, 0);
        tx_idle = 1'b1;
    endtask

    task automatic test_random_stream();
        int         first;
        int         pick;
        int         r;
        int         len;
        logic [7:0] nb;
        first = bytes_sent;
        while (bytes_sent - first < 500)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                tx_idle = 1'($urandom_range(0, 1));
                rx_idle = 1'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 19);
            if (pick < 16)
            begin
                resync();
                r = $urandom_range(0, 39);
                len = (r < 4) ? 0 : (r < 36) ? $urandom_range(1, 12) :
                      (r < 39) ? $urandom_range(13, 60) : $urandom_range(128, 200);
                send_packet(8'($urandom_range(0, 255)), len,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 8);
            end
            else if (pick < 18)
            begin
                resync();
                send_byte(8'($urandom_range(0, 255)), seg_mark(8));
                repeat (MAX_LEN_BYTES)
                    send_byte(8'h80 | 8'($urandom_range(0, 127)), seg_mark(8));
            end
            else
            begin
                if (pick == 19)
                begin
                    // truncated packet: payload cut short, then junk follows
                    resync();
                    len = $urandom_range(2, 20);
                    send_byte(8'($urandom_range(0, 255)), seg_mark(8));
                    send_byte(len[7:0], seg_mark(8));
                    repeat ($urandom_range(0, len - 1))
                        send_byte(8'($urandom_range(0, 255)), seg_mark(8));
                end
                repeat ($urandom_range(1, 6))
                begin
                    nb = 8'($urandom_range(0, 255));
                    // keep junk lengths short so payloads stay small
                    if (fr_phase == mpf_pkg::PH_LENGTH)
                    begin
                        if (len_groups >= 2)
                            nb[7] = 1'b1;
                        else if (len_groups == 1)
                            nb[6:1] = '0;
                    end
                    send_byte(nb, seg_mark(4));
                end
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 11) : 0;
            if (rx_hold > 0)
            begin
                gap = rx_hold;
                rx_hold = 0;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        mpf_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (byte_verdicts_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: role %0d end %0b bad %0b len %0d more %0b",
                             m_tuser, m_tlast, m_tdata[0], m_tdata[28:1], m_tdata[29]);
            end
            else
            begin
                want = byte_verdicts_q.pop_front();
                if (m_tuser !== want.byte_role || m_tlast !== want.packet_end ||
                    m_tdata[0] !== want.malformed || m_tdata[28:1] !== want.packet_length ||
                    m_tdata[29] !== want.need_more)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp role %0d end %0b bad %0b len %0d more %0b",
                                  " / got role %0d end %0b bad %0b len %0d more %0b"},
                                 want.byte_role, want.packet_end, want.malformed,
                                 want.packet_length, want.need_more,
                                 m_tuser, m_tlast, m_tdata[0], m_tdata[28:1], m_tdata[29]);
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        rx_hold    = 0;
        mismatches = 0;
        bytes_sent = 0;
        fr_phase   = mpf_pkg::PH_HEADER;
        len_sum    = '0;
        body_left  = '0;
        len_groups = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_length();
        test_malformed_length();
        test_padded_length();
        test_segment_marks();
        test_backpressure();
        test_random_stream();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (byte_verdicts_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
